// File: hw/rtl/rwa_pkg.sv
package rwa_pkg;

  // Width of the window register and of the reported fill count.
  localparam int WINDOW_BITS = 7;
  localparam int FILL_BITS   = 7;

  // Configuration port geometry.
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  // Window register reset value.
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 7'd64;

  // Register index, taken from paddr[ADDR_BITS-1].
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // Request kinds carried in tuser.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Status of the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: hw/rtl/rwa_ring_store.sv
module rwa_ring_store #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_WIDTH-1:0]    wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_WIDTH-1:0]    rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port: data appears in the cycle after the read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/rwa_divider.sv
module rwa_divider
  import rwa_pkg::*;
#(
  parameter int NUM_BITS = 22
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [NUM_BITS-1:0] dividend,
  input  logic [FILL_BITS-1:0]       divisor,
  output div_status_t                status,
  output logic signed [NUM_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(NUM_BITS);

  logic                  busy;
  logic                  done;
  logic                  neg;
  logic [CNT_BITS-1:0]   step_cnt;
  logic [FILL_BITS-1:0]  rem;
  logic [FILL_BITS-1:0]  dvs;
  logic [NUM_BITS-1:0]   quot;
  logic [FILL_BITS:0]    shifted;
  logic [FILL_BITS:0]    trial;
  logic                  fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign shifted = {rem, quot[NUM_BITS-1]};
  assign trial   = shifted - {1'b0, dvs};
  assign fits    = ~trial[FILL_BITS];

  // Control: busy for NUM_BITS steps, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step_cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: divide the magnitude, remember the sign.
  always_ff @(posedge clk) begin
    if (start) begin
      neg      <= dividend[NUM_BITS-1];
      quot     <= dividend[NUM_BITS-1] ? (~dividend + 1'b1) : dividend;
      rem      <= '0;
      dvs      <= divisor;
      step_cnt <= CNT_BITS'(NUM_BITS - 1);
    end else if (busy) begin
      rem      <= fits ? trial[FILL_BITS-1:0] : shifted[FILL_BITS-1:0];
      quot     <= {quot[NUM_BITS-2:0], fits};
      step_cnt <= step_cnt - 1'b1;
    end
  end

  // Truncation toward zero: negate the magnitude quotient for a negative sum.
  assign quotient    = neg ? -$signed(quot) : $signed(quot);
  assign status.busy = busy;
  assign status.done = done;

  // A new division never starts on top of a running one.
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

  // The done pulse follows the last step.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("divider done without a finished run");

endmodule

// File: hw/rtl/running_window_average.sv
// Channel   Direction  Transaction contents
// s_*       in         tuser[0] = req_type, tdata = sample
// m_*       out        tdata = average, filled
// p*        in/out     APB register port, window_size at byte address 0
//
// A sample request holds the block through acceptance, one memory read, one update,
// the divider start, one quotient bit per cycle plus a done pulse, and the output
// load, which waits while m_* still holds an earlier result. A clear request is
// applied when it is accepted and leaves the block idle.
// rst is synchronous and active high; the store needs no clearing pass,
// since the fill count marks entries not yet written since the last clear.
// A result held on m_* does not stop the next request; only a second
// result waits in the output state until the first transaction completes.
module running_window_average
  import rwa_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  // Input stream
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  // tdata fields from bit 0: sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]             s_tdata,
  // tuser fields from bit 0: req_type
  input  logic [0:0]                                   s_tuser,
  // Output stream
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  // tdata fields from bit 0: average, filled
  output logic [((SAMPLE_BITS+FILL_BITS+7)/8)*8-1:0]   m_tdata,
  // Register port
  input  logic                                         psel,
  input  logic                                         penable,
  input  logic                                         pwrite,
  input  logic [ADDR_BITS-1:0]                         paddr,
  input  logic [DATA_BITS-1:0]                         pwdata,
  output logic [DATA_BITS-1:0]                         prdata,
  output logic                                         pready
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int SUM_BITS = SAMPLE_BITS + PTR_BITS;
  localparam int OUT_BITS = ((SAMPLE_BITS + FILL_BITS + 7) / 8) * 8;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_UPDATE = 6'b000100,
    ST_START  = 6'b001000,
    ST_DIVIDE = 6'b010000,
    ST_OUTPUT = 6'b100000
  } rwa_state_t;

  rwa_state_t                  state;
  rwa_state_t                  state_next;
  logic [WINDOW_BITS-1:0]      window_size;
  logic [WINDOW_BITS-1:0]      win;
  logic [PTR_BITS-1:0]         write_pointer;
  logic [FILL_BITS-1:0]        fill_count;
  logic signed [SUM_BITS-1:0]  running_sum;
  logic signed [SUM_BITS-1:0]  sum_next;
  logic signed [SAMPLE_BITS-1:0] sample_reg;
  logic signed [SAMPLE_BITS-1:0] evicted;
  logic [SAMPLE_BITS-1:0]      rd_data;
  logic                        cfg_wr;
  logic                        in_accept;
  logic                        out_load;
  div_status_t                 div_stat;
  logic signed [SUM_BITS-1:0]  div_quot;

  // Register port: always ready, one register.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready &
                  (paddr[ADDR_BITS-1] == REG_WINDOW_SIZE);
  assign prdata = (paddr[ADDR_BITS-1] == REG_WINDOW_SIZE) ? DATA_BITS'(window_size) : '0;

  // Effective window: zero acts as one, large values saturate at DEPTH.
  always_comb begin
    if (window_size == '0) begin
      win = WINDOW_BITS'(1);
    end else if (32'(window_size) > 32'(DEPTH)) begin
      win = WINDOW_BITS'(DEPTH);
    end else begin
      win = window_size;
    end
  end

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid & s_tready;
  assign out_load  = (state == ST_OUTPUT) && (!m_tvalid || m_tready);

  // An entry not yet written since the last clear reads as zero.
  assign evicted  = (fill_count < win) ? '0 : $signed(rd_data);
  assign sum_next = running_sum - SUM_BITS'(evicted) + SUM_BITS'(sample_reg);

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && s_tuser[0] == REQ_SAMPLE) begin
          state_next = ST_READ;
        end
      end
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_START;
      ST_START:  state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_next = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window register, pointer, fill count and running sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WINDOW_RESET;
      write_pointer <= '0;
      fill_count    <= '0;
      running_sum   <= '0;
    end else if (cfg_wr) begin
      window_size   <= pwdata[WINDOW_BITS-1:0];
      write_pointer <= '0;
      fill_count    <= '0;
      running_sum   <= '0;
    end else if (in_accept && s_tuser[0] == REQ_CLEAR) begin
      write_pointer <= '0;
      fill_count    <= '0;
      running_sum   <= '0;
    end else if (state == ST_UPDATE) begin
      running_sum <= sum_next;
      if (32'(write_pointer) + 32'd1 >= 32'(win)) begin
        write_pointer <= '0;
      end else begin
        write_pointer <= write_pointer + 1'b1;
      end
      if (fill_count < win) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // Sample capture on an accepted transaction.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_reg <= $signed(s_tdata[SAMPLE_BITS-1:0]);
    end
  end

  // Output register, parted from the core so a new request can proceed.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_BITS'({fill_count, div_quot[SAMPLE_BITS-1:0]});
    end
  end

  rwa_ring_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (SAMPLE_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (state == ST_UPDATE),
    .wr_addr (write_pointer),
    .wr_data (sample_reg),
    .rd_en   (state == ST_READ),
    .rd_addr (write_pointer),
    .rd_data (rd_data)
  );

  rwa_divider #(
    .NUM_BITS (SUM_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_START),
    .dividend (running_sum),
    .divisor  (fill_count),
    .status   (div_stat),
    .quotient (div_quot)
  );

  // The fill count never runs past the effective window.
  a_fill_in_window: assert property (@(posedge clk) disable iff (rst)
    fill_count <= win)
    else $error("fill count exceeds window");

  // The ring pointer stays inside the window.
  a_ptr_in_window: assert property (@(posedge clk) disable iff (rst)
    32'(write_pointer) < 32'(win))
    else $error("write pointer outside window");

  // While waiting on the quotient, the divider is running or just finished.
  a_div_running: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIVIDE |-> div_stat.busy || div_stat.done)
    else $error("waiting on an idle divider");

  // A finished result waits while the output register is still occupied.
  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUTPUT && m_tvalid && !m_tready) |=> state == ST_OUTPUT)
    else $error("result dropped while output stalled");

endmodule

// File: tb/running_window_average_tb.sv
`timescale 1ns / 100ps

module running_window_average_tb;
  import rwa_pkg::*;

  localparam int DEPTH        = 64;
  localparam int SAMPLE_BITS  = 16;
  localparam int SUM_BITS     = 22;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 550;

  localparam logic [ADDR_BITS-1:0] WINDOW_ADDR = 3'd0;
  localparam logic [ADDR_BITS-1:0] UNUSED_ADDR = 3'd4;

  typedef struct packed {
    logic                   req_type;
    logic [SAMPLE_BITS-1:0] sample;
  } sample_req_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average;
    logic [FILL_BITS-1:0]   filled;
  } window_result_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // Fields from bit 0: sample.
  logic [15:0]          s_tdata  = '0;
  // Fields from bit 0: req_type.
  logic [0:0]           s_tuser  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // Fields from bit 0: average, filled.
  logic [23:0]          m_tdata;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [ADDR_BITS-1:0] paddr    = '0;
  logic [DATA_BITS-1:0] pwdata   = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  sample_req_t    pending_reqs[$];
  window_result_t expected_averages[$];
  sample_req_t    req_on_bus;
  int unsigned    reqs_queued    = 0;
  int unsigned    reqs_accepted  = 0;
  int unsigned    mismatch_count = 0;
  int unsigned    send_idle_pct  = 21;
  int unsigned    recv_idle_pct  = 59;

  // Shadow copy of the averaging state.
  logic [WINDOW_BITS-1:0]        window_reg;
  logic signed [SAMPLE_BITS-1:0] window_store [DEPTH];
  logic [5:0]                    store_ptr;
  logic [FILL_BITS-1:0]          fill_cnt;
  logic signed [SUM_BITS-1:0]    window_sum;

  running_window_average #(
    .DEPTH      (DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  function automatic void clear_window();
    foreach (window_store[i]) window_store[i] = '0;
    store_ptr  = '0;
    fill_cnt   = '0;
    window_sum = '0;
  endfunction

  // Applies one accepted request to the shadow state and queues the average a sample yields.
  function automatic void predict_average(input sample_req_t req);
    logic [WINDOW_BITS-1:0]     eff;
    logic signed [SUM_BITS-1:0] quotient;
    window_result_t             res;
    if (req.req_type == REQ_CLEAR) begin
      clear_window();
      return;
    end
    // A zero window acts as one entry; anything above the store depth saturates.
    if (window_reg == '0) begin
      eff = 7'd1;
    end else if (window_reg > DEPTH) begin
      eff = 7'(DEPTH);
    end else begin
      eff = window_reg;
    end
    if ({1'b0, store_ptr} >= eff) store_ptr = '0;
    window_sum = window_sum - window_store[store_ptr] + $signed(req.sample);
    window_store[store_ptr] = $signed(req.sample);
    if ({1'b0, store_ptr} + 7'd1 >= eff) begin
      store_ptr = '0;
    end else begin
      store_ptr = store_ptr + 6'd1;
    end
    if (fill_cnt < eff) fill_cnt = fill_cnt + 7'd1;
    // Signed division truncates toward zero.
    quotient = window_sum / $signed({1'b0, fill_cnt});
    res.average = quotient[SAMPLE_BITS-1:0];
    res.filled  = fill_cnt;
    expected_averages.push_back(res);
  endfunction

  function automatic void queue_req(input logic kind, input logic [SAMPLE_BITS-1:0] value);
    sample_req_t req;
    req.req_type = kind;
    req.sample   = value;
    pending_reqs.push_back(req);
    reqs_queued++;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(31)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  // Writes a register over APB, then reads the window register back.
  task automatic write_window_reg(input logic [ADDR_BITS-1:0] addr,
                                  input logic [DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[ADDR_BITS-1] == REG_WINDOW_SIZE) begin
      window_reg = data[WINDOW_BITS-1:0];
      clear_window();
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= WINDOW_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(window_reg)) begin
      $display("%0t: window register read expected %0d actual %0d",
               $time, window_reg, prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits until every request is taken and every average has come, then lets
  // a trailing clear settle.
  task automatic drain_and_idle();
    @(posedge clk);
    while (reqs_accepted != reqs_queued || expected_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Request driver: presents queued requests and predicts each accepted transaction.
  always @(posedge clk) begin : request_driver
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_average(req_on_bus);
        reqs_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_on_bus = pending_reqs.pop_front();
          s_tvalid   <= 1'b1;
          s_tdata    <= req_on_bus.sample;
          s_tuser    <= req_on_bus.req_type;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each output transaction with the oldest prediction.
  always @(posedge clk) begin : result_monitor
    window_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_averages.size() == 0) begin
          $display("%0t: unexpected result, expected none actual average %0d filled %0d",
                   $time, $signed(m_tdata[15:0]), m_tdata[22:16]);
          mismatch_count++;
        end else begin
          want = expected_averages.pop_front();
          if (m_tdata[15:0] !== want.average) begin
            $display("%0t: average expected %0d actual %0d", $time,
                     $signed(want.average), $signed(m_tdata[15:0]));
            mismatch_count++;
          end
          if (m_tdata[22:16] !== want.filled) begin
            $display("%0t: filled expected %0d actual %0d", $time,
                     want.filled, m_tdata[22:16]);
            mismatch_count++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stimulus sequence.
  initial begin
    int unsigned            random_sent;
    int unsigned            eff;
    int unsigned            seg_len;
    logic [WINDOW_BITS-1:0] win_val;
    logic [DATA_BITS-1:0]   wdata;
    random_sent = 0;
    window_reg  = WINDOW_RESET;
    clear_window();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Full-scale samples and clears at the reset window; a clear ignores its sample.
    queue_req(REQ_SAMPLE, 16'h7FFF);
    queue_req(REQ_SAMPLE, 16'h8000);
    queue_req(REQ_SAMPLE, 16'hFFFF);
    queue_req(REQ_SAMPLE, 16'h0001);
    queue_req(REQ_SAMPLE, 16'h0000);
    queue_req(REQ_CLEAR,  16'h7FFF);
    repeat (3) queue_req(REQ_SAMPLE, 16'h8000);
    queue_req(REQ_CLEAR,  16'h0000);
    queue_req(REQ_SAMPLE, 16'hFFFD);
    drain_and_idle();

    // A zero window passes samples straight through.
    write_window_reg(WINDOW_ADDR, 32'd0);
    queue_req(REQ_SAMPLE, 16'h7FFF);
    queue_req(REQ_SAMPLE, 16'h8000);
    queue_req(REQ_SAMPLE, 16'hFFFB);
    drain_and_idle();

    // A window above the store depth saturates.
    write_window_reg(WINDOW_ADDR, 32'd100);
    queue_req(REQ_SAMPLE, 16'h8000);
    queue_req(REQ_SAMPLE, 16'h7FFF);
    drain_and_idle();

    // A write outside the register map leaves the window and its contents alone.
    write_window_reg(UNUSED_ADDR, 32'd1);
    queue_req(REQ_SAMPLE, 16'h0010);
    drain_and_idle();

    // Two-entry window: odd negative sums check truncation toward zero.
    write_window_reg(WINDOW_ADDR, 32'd2);
    queue_req(REQ_SAMPLE, 16'h0003);
    queue_req(REQ_SAMPLE, 16'hFFFC);
    queue_req(REQ_SAMPLE, 16'hFFFD);
    queue_req(REQ_SAMPLE, 16'h0005);
    drain_and_idle();

    // Upper data bits beyond the register width are dropped.
    write_window_reg(WINDOW_ADDR, 32'hFFFF_FF81);
    queue_req(REQ_SAMPLE, 16'h1234);
    queue_req(REQ_SAMPLE, 16'h8000);
    drain_and_idle();

    // Random segments, each at its own window; the sender waits for the
    // block to drain before every window change.
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 59;
      end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(9))
        0: win_val = 7'd0;
        1: win_val = 7'd1;
        2: win_val = 7'd2;
        3: win_val = 7'd64;
        4: win_val = 7'($urandom_range(127, 65));
        5: win_val = 7'($urandom_range(8, 3));
        default: win_val = 7'($urandom_range(64, 1));
      endcase
      wdata = 32'(win_val);
      if ($urandom_range(3) == 0) wdata[31:7] = 25'($urandom);
      write_window_reg(WINDOW_ADDR, wdata);
      if (win_val == 0) begin
        eff = 1;
      end else if (win_val > DEPTH) begin
        eff = DEPTH;
      end else begin
        eff = win_val;
      end
      seg_len = 2 * eff + $urandom_range(20, 4);
      // The last segment stops at the planned item count.
      if (seg_len > RANDOM_ITEMS - random_sent) seg_len = RANDOM_ITEMS - random_sent;
      repeat (seg_len) begin
        if ($urandom_range(24) == 0) begin
          queue_req(REQ_CLEAR, 16'($urandom));
        end else begin
          queue_req(REQ_SAMPLE, random_sample());
        end
      end
      random_sent += seg_len;
      drain_and_idle();
    end

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
